/* hdl/rho_pkg.sv */
// Shared types, constants and datapath functions for the RGB hue offset core.
// Used by rho_front, rho_queue, rho_back and rgb_hue_offset_core; depends on nothing.
package rho_pkg;

  // Channel, mix and quotient widths
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned MixW     = 16;            // weight sum <= 255, so a mix <= 255*255
  localparam int unsigned NumW     = MixW + ChanW;  // mix times largest input channel
  localparam int unsigned DivSteps = ChanW;         // quotient never exceeds a channel byte
  localparam int unsigned OffW     = 10;            // signed working width for the offset

  // Hue wheel thirds
  localparam int unsigned HueThird     = 85;
  localparam int unsigned HueTwoThirds = 170;
  localparam logic signed [OffW-1:0] ThirdS     = OffW'(HueThird);
  localparam logic signed [OffW-1:0] TwoThirdsS = OffW'(HueTwoThirds);

  // Configuration register indexes
  typedef enum logic {
    RegHueOffset = 1'b0
  } reg_idx_e;

  // Index 0 is red, 1 green, 2 blue
  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    pixel_t           pix;
    logic [ChanW-1:0] w_left;
    logic [ChanW-1:0] w_mid;
    logic [ChanW-1:0] w_right;
    logic             pass;
  } item_t;

  // One channel of the restoring divider: partial remainder and shifting quotient
  typedef struct packed {
    logic [MixW-1:0]  rem;
    logic [ChanW-1:0] quo;
  } div_t;

  // Clamp a signed value at zero; positive values stay below 86 here
  function automatic logic [ChanW-1:0] clamp_pos(input logic signed [OffW-1:0] v);
    return v[OffW-1] ? '0 : v[ChanW-1:0];
  endfunction

  // Scale a base weight of at most 85 up to at most 255
  function automatic logic [ChanW-1:0] times3(input logic [ChanW-1:0] b);
    logic [ChanW+1:0] s;
    s = {1'b0, b, 1'b0} + {2'b00, b};
    return s[ChanW-1:0];
  endfunction

  // Derive the three mixing weights and the pass-through flag for one pixel
  function automatic item_t classify(input pixel_t pix, input logic [ChanW-1:0] hue);
    logic signed [OffW-1:0] ov;
    logic [ChanW-1:0] bm;
    logic [ChanW-1:0] bl;
    logic [ChanW-1:0] br;
    item_t it;
    ov = {{(OffW-ChanW){hue[ChanW-1]}}, hue};
    if (ov < 0) begin
      bm = clamp_pos(ov + ThirdS);
    end else begin
      bm = clamp_pos(ThirdS - ov);
    end
    if (ov < -ThirdS) begin
      bl = clamp_pos(TwoThirdsS + ov);
    end else begin
      bl = clamp_pos(-ov);
    end
    if (ov > ThirdS) begin
      br = clamp_pos(TwoThirdsS - ov);
    end else begin
      br = clamp_pos(ov);
    end
    it.pix     = pix;
    it.w_left  = times3(bl);
    it.w_mid   = times3(bm);
    it.w_right = times3(br);
    it.pass    = (hue == '0);
    return it;
  endfunction

  function automatic logic [ChanW-1:0] max3_chan(input pixel_t p);
    logic [ChanW-1:0] m;
    m = (p[0] > p[1]) ? p[0] : p[1];
    return (m > p[2]) ? m : p[2];
  endfunction

  function automatic logic [MixW-1:0] max3_mix(input logic [NumChan-1:0][MixW-1:0] x);
    logic [MixW-1:0] m;
    m = (x[0] > x[1]) ? x[0] : x[1];
    return (m > x[2]) ? m : x[2];
  endfunction

  // One restoring division step: bring down the next numerator bit, compare, subtract
  function automatic div_t div_step(input div_t s, input logic [MixW-1:0] den);
    logic [MixW:0] t;
    logic [MixW:0] diff;
    div_t r;
    t    = {s.rem, s.quo[ChanW-1]};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      r.rem = diff[MixW-1:0];
      r.quo = {s.quo[ChanW-2:0], 1'b1};
    end else begin
      r.rem = t[MixW-1:0];
      r.quo = {s.quo[ChanW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* hdl/rho_front.sv */
// Front stage: accepts pixels, derives weights and the pass-through flag.
// Depends on rho_pkg; feeds rho_queue.
module rho_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rho_pkg::pixel_t             pix_i,
  input  logic [rho_pkg::ChanW-1:0]   hue_offset_i,
  output logic                        push_o,
  output rho_pkg::item_t              item_o,
  input  logic                        full_i
);

  logic           valid_q, valid_d;
  rho_pkg::item_t item_q;
  logic           accept;

  // Take a new pixel whenever the held one moves on or none is held
  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Classify at acceptance
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= rho_pkg::classify(pix_i, hue_offset_i);
    end
  end

endmodule

/* hdl/rho_queue.sv */
// Short FIFO of classified items between the front and the back.
// Depends on rho_pkg for the item type.
module rho_queue #(
  parameter int unsigned Depth = 2  // two or more entries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rho_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rho_pkg::item_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rho_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the last entry
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  // Track fill level
  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1 && count_q <= CntW'(Depth))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");
`endif

endmodule

/* hdl/rho_back.sv */
// Back pipeline: channel mix, peak rescale numerators and an 8-stage restoring divider.
// Depends on rho_pkg; takes items from rho_queue and drives the output register.
module rho_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  rho_pkg::item_t  item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rho_pkg::pixel_t pix_o
);

  localparam int unsigned NC = rho_pkg::NumChan;
  localparam int unsigned DS = rho_pkg::DivSteps;

  logic adv;

  // Product stage
  logic                                s1_vld_q;
  rho_pkg::pixel_t                     s1_pix_q;
  logic                                s1_pass_q;
  logic [NC-1:0][rho_pkg::MixW-1:0]    s1_pl_q, s1_pm_q, s1_pr_q;

  // Sum stage
  logic                                s2_vld_q;
  rho_pkg::pixel_t                     s2_pix_q;
  logic                                s2_pass_q;
  logic [NC-1:0][rho_pkg::MixW-1:0]    s2_mix_q;
  logic [rho_pkg::ChanW-1:0]           s2_peak_q;

  // Numerator stage and divider steps, index 0 is the divider's entry
  logic                                dv_vld_q  [DS+1];
  rho_pkg::pixel_t                     dv_pix_q  [DS+1];
  logic                                dv_pass_q [DS+1];
  logic [rho_pkg::MixW-1:0]            dv_den_q  [DS+1];
  rho_pkg::div_t [NC-1:0]              dv_st_q   [DS+1];
  rho_pkg::div_t [NC-1:0]              dv_next   [DS+1];

  logic [rho_pkg::MixW-1:0]            s3_den;
  logic [NC-1:0][rho_pkg::NumW-1:0]    s3_num;

  // Output register
  logic                                out_vld_q;
  rho_pkg::pixel_t                     out_pix_q;
  rho_pkg::pixel_t                     out_pix_d;

  // Whole pipeline moves together unless a finished pixel waits
  assign adv         = !out_vld_q || out_ready_i;
  assign pop_o       = adv && item_valid_i;
  assign out_valid_o = out_vld_q;
  assign pix_o       = out_pix_q;

  // Numerators and common denominator from the mixed channels
  always_comb begin
    s3_den = rho_pkg::max3_mix(s2_mix_q);
    for (int c = 0; c < NC; c++) begin
      s3_num[c] = rho_pkg::NumW'(s2_mix_q[c]) * rho_pkg::NumW'(s2_peak_q);
    end
  end

  // Divider steps, one quotient bit per stage
  always_comb begin
    dv_next[0] = dv_st_q[0];
    for (int k = 1; k <= DS; k++) begin
      for (int c = 0; c < NC; c++) begin
        dv_next[k][c] = rho_pkg::div_step(dv_st_q[k-1][c], dv_den_q[k-1]);
      end
    end
  end

  // Pick pass-through pixel or the rescaled quotients
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      out_pix_d[c] = dv_pass_q[DS] ? dv_pix_q[DS][c] : dv_st_q[DS][c].quo;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k <= DS; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      s1_vld_q    <= pop_o;
      s2_vld_q    <= s1_vld_q;
      dv_vld_q[0] <= s2_vld_q;
      for (int k = 1; k <= DS; k++) begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
      out_vld_q <= dv_vld_q[DS];
    end
  end

  // Payload, advanced with the valid bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Weighted products, cyclic neighbors of each channel
      s1_pix_q  <= item_i.pix;
      s1_pass_q <= item_i.pass;
      for (int c = 0; c < NC; c++) begin
        s1_pl_q[c] <= item_i.w_left  * item_i.pix[(c + 2) % NC];
        s1_pm_q[c] <= item_i.w_mid   * item_i.pix[c];
        s1_pr_q[c] <= item_i.w_right * item_i.pix[(c + 1) % NC];
      end
      // Mixed channels and largest input channel
      s2_pix_q  <= s1_pix_q;
      s2_pass_q <= s1_pass_q;
      s2_peak_q <= rho_pkg::max3_chan(s1_pix_q);
      for (int c = 0; c < NC; c++) begin
        s2_mix_q[c] <= s1_pl_q[c] + s1_pm_q[c] + s1_pr_q[c];
      end
      // Load the divider; a black mix passes the pixel through
      dv_pix_q[0]  <= s2_pix_q;
      dv_pass_q[0] <= s2_pass_q || (s3_den == '0);
      dv_den_q[0]  <= s3_den;
      for (int c = 0; c < NC; c++) begin
        dv_st_q[0][c].rem <= s3_num[c][rho_pkg::NumW-1:rho_pkg::ChanW];
        dv_st_q[0][c].quo <= s3_num[c][rho_pkg::ChanW-1:0];
      end
      for (int k = 1; k <= DS; k++) begin
        dv_pix_q[k]  <= dv_pix_q[k-1];
        dv_pass_q[k] <= dv_pass_q[k-1];
        dv_den_q[k]  <= dv_den_q[k-1];
        dv_st_q[k]   <= dv_next[k];
      end
      out_pix_q <= out_pix_d;
    end
  end

`ifndef ASSERT_OFF
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[DS] && !dv_pass_q[DS] |->
      dv_st_q[DS][0].rem < dv_den_q[DS] &&
      dv_st_q[DS][1].rem < dv_den_q[DS] &&
      dv_st_q[DS][2].rem < dv_den_q[DS])
    else $error("divider remainder not below denominator");
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_vld_q[DS]) && $stable(s1_vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

/* hdl/rgb_hue_offset_core.sv */
// RGB hue offset core: top level with configuration register, front, queue and back.
// Depends on rho_pkg, rho_front, rho_queue and rho_back.
//
// Shifts the hue of one 8-bit RGB pixel per clock, while the queue and output do not stall,
// by the signed hue_offset register (byte address 0, low 8 bits). Each result passes
// through the weight register in the front, the queue, the product, sum and numerator
// stages, the one-bit-per-stage divider that rescales to the brightest input channel,
// and the output register. A zero offset or a black pixel comes out unchanged. Write the
// register only while no pixel is in flight.
module rgb_hue_offset_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // Pixel in
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rho_pkg::ChanW-1:0] red_in_i,
  input  logic [rho_pkg::ChanW-1:0] green_in_i,
  input  logic [rho_pkg::ChanW-1:0] blue_in_i,
  // Pixel out
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rho_pkg::ChanW-1:0] red_out_o,
  output logic [rho_pkg::ChanW-1:0] green_out_o,
  output logic [rho_pkg::ChanW-1:0] blue_out_o
);

  logic [rho_pkg::ChanW-1:0] hue_offset_q;
  logic                      cfg_wr;
  logic                      reg_hit;

  rho_pkg::pixel_t in_pix;
  rho_pkg::pixel_t out_pix;
  rho_pkg::item_t  fe_item;
  rho_pkg::item_t  q_item;
  logic            fe_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  // Register decode on the word index
  assign reg_hit = (paddr[2] == rho_pkg::RegHueOffset);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(32 - rho_pkg::ChanW){1'b0}}, hue_offset_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_offset_q <= '0;
    end else if (cfg_wr) begin
      hue_offset_q <= pwdata[rho_pkg::ChanW-1:0];
    end
  end

  assign in_pix[0] = red_in_i;
  assign in_pix[1] = green_in_i;
  assign in_pix[2] = blue_in_i;

  rho_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pix_i        (in_pix),
    .hue_offset_i (hue_offset_q),
    .push_o       (fe_push),
    .item_o       (fe_item),
    .full_i       (q_full)
  );

  rho_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  rho_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pix_o        (out_pix)
  );

  assign red_out_o   = out_pix[0];
  assign green_out_o = out_pix[1];
  assign blue_out_o  = out_pix[2];

endmodule

/* bench/hue_shift_checker.sv */
// Scoreboard for rgb_hue_offset_core: mirrors the hue offset register, predicts each pixel
// and compares the results in order. Depends on rho_pkg.
module hue_shift_checker
  import rho_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration port, watched only
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [2:0]       paddr_i,
  input  logic [31:0]      pwdata_i,
  input  logic             pready_i,
  // Pixel in
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [ChanW-1:0] red_in_i,
  input  logic [ChanW-1:0] green_in_i,
  input  logic [ChanW-1:0] blue_in_i,
  // Pixel out
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [ChanW-1:0] red_out_i,
  input  logic [ChanW-1:0] green_out_i,
  input  logic [ChanW-1:0] blue_out_i,
  // Status for the bench
  output int               errors_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] HueAddr = {RegHueOffset, 2'b00};

  logic signed [ChanW-1:0] hue_shadow;
  pixel_t                  expected_pixels[$];

  task automatic flag_mismatch(input string msg);
    $display("hue_shift_checker: %0t ns: %s", $time, msg);
    errors_o++;
  endtask

  function automatic int floor0(input int v);
    return (v > 0) ? v : 0;
  endfunction

  function automatic int peak3(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Weight the three channels cyclically, then rescale to the brightest input channel
  function automatic pixel_t shift_hue(input logic signed [ChanW-1:0] offset, input pixel_t px);
    int     o;
    int     third;
    int     two_thirds;
    int     w_l;
    int     w_m;
    int     w_r;
    int     r;
    int     g;
    int     b;
    int     mix_r;
    int     mix_g;
    int     mix_b;
    int     top_in;
    int     top_mix;
    pixel_t res;
    o          = offset;
    third      = HueThird;
    two_thirds = HueTwoThirds;
    r          = int'(px[0]);
    g          = int'(px[1]);
    b          = int'(px[2]);
    res        = px;
    if (o == 0) begin
      return res;
    end
    w_m = 3 * ((o < 0) ? floor0(o + third) : floor0(third - o));
    w_l = 3 * ((o < -third) ? floor0(two_thirds + o) : floor0(-o));
    w_r = 3 * ((o > third) ? floor0(two_thirds - o) : floor0(o));
    mix_r   = w_l * b + w_m * r + w_r * g;
    mix_g   = w_l * r + w_m * g + w_r * b;
    mix_b   = w_l * g + w_m * b + w_r * r;
    top_in  = peak3(r, g, b);
    top_mix = peak3(mix_r, mix_g, mix_b);
    // Black pixel: nothing to rescale
    if (top_mix == 0) begin
      return res;
    end
    res[0] = ChanW'((mix_r * top_in) / top_mix);
    res[1] = ChanW'((mix_g * top_in) / top_mix);
    res[2] = ChanW'((mix_b * top_in) / top_mix);
    return res;
  endfunction

  task automatic check_channel(input string chan, input logic [ChanW-1:0] got,
                               input logic [ChanW-1:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s_out is %0d, expected %0d", chan, got, want));
    end
  endtask

  // Track the register, queue predictions on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      hue_shadow = '0;
      expected_pixels.delete();
      outstanding_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == HueAddr) begin
        hue_shadow = pwdata_i[ChanW-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        expected_pixels.push_back(shift_hue(hue_shadow, {blue_in_i, green_in_i, red_in_i}));
      end
      if (out_valid_i && out_ready_i) begin
        got = {blue_out_i, green_out_i, red_out_i};
        if (expected_pixels.size() == 0) begin
          flag_mismatch($sformatf("unexpected item %0d/%0d/%0d",
                                  red_out_i, green_out_i, blue_out_i));
        end else begin
          want = expected_pixels.pop_front();
          check_channel("red", got[0], want[0]);
          check_channel("green", got[1], want[1]);
          check_channel("blue", got[2], want[2]);
        end
      end
      outstanding_o = expected_pixels.size();
    end
  end

endmodule

/* bench/tb.sv */
// Top of the hue offset bench: clock, reset, register writes, pixel stimulus and verdict.
// Depends on rho_pkg, rgb_hue_offset_core and hue_shift_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rho_pkg::*;

  localparam time Period      = 20ns;
  localparam int  ResetCycles = 12;
  localparam int  PhaseItems  = 62;
  localparam int  NumPhases   = 12;
  localparam int  LongStall   = 400;
  localparam int  TailCycles  = 40;
  localparam int  StallLimit  = 3000;
  localparam logic [2:0] HueAddr = {RegHueOffset, 2'b00};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ChanW-1:0] red_in_i;
  logic [ChanW-1:0] green_in_i;
  logic [ChanW-1:0] blue_in_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ChanW-1:0] red_out_o;
  logic [ChanW-1:0] green_out_o;
  logic [ChanW-1:0] blue_out_o;

  int   errors;
  int   outstanding;
  int   quiet_cycles;
  logic steady_mode = 1'b0;
  logic stall_req   = 1'b0;

  rgb_hue_offset_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  hue_shift_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_out_i     (red_out_o),
    .green_out_i   (green_out_o),
    .blue_out_i    (blue_out_o),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  always #(Period / 2) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t mk_pixel(input int r, input int g, input int b);
    return {ChanW'(b), ChanW'(g), ChanW'(r)};
  endfunction

  // Offer one item after an optional gap and hold it until accepted
  task automatic push_pixel(input pixel_t px, input int gap);
    logic taken;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= px[0];
    green_in_i <= px[1];
    blue_in_i  <= px[2];
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Setup cycle, then access cycle; upper data bits are junk the block must ignore
  task automatic write_hue(input logic [ChanW-1:0] hue);
    logic done;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HueAddr;
    pwdata  <= {24'($urandom), hue};
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  // Drain side: random ready, one long hold-off on request
  initial begin : result_sink
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_len();
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
      end else if (steady_mode || gap == 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    pixel_t corners [8];
    int     fixed_hue [7];
    int     corner_hue [3];
    pixel_t px;
    int     k;
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    red_in_i   <= '0;
    green_in_i <= '0;
    blue_in_i  <= '0;
    corners[0] = mk_pixel(0, 0, 0);
    corners[1] = mk_pixel(255, 255, 255);
    corners[2] = mk_pixel(255, 0, 0);
    corners[3] = mk_pixel(0, 255, 0);
    corners[4] = mk_pixel(0, 0, 255);
    corners[5] = mk_pixel(1, 0, 0);
    corners[6] = mk_pixel(255, 128, 1);
    corners[7] = mk_pixel(128, 64, 200);
    corner_hue = '{0, 127, -128};
    fixed_hue  = '{85, -85, 86, -86, 1, -1, 0};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner pixels at the reset offset and at both offset extremes
    for (int d = 0; d < 3; d++) begin
      if (d > 0) begin
        write_hue(ChanW'(corner_hue[d]));
      end
      foreach (corners[i]) begin
        push_pixel(corners[i], idle_len());
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    // Random pixels, one offset per phase
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 3) begin
        stall_req = 1'b1;
      end
      write_hue((p < 7) ? ChanW'(fixed_hue[p]) : ChanW'($urandom));
      steady_mode = (p == 5 || p == 9);
      for (int i = 0; i < PhaseItems; i++) begin
        px = 24'($urandom);
        k  = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
          0: px = '0;
          1: px = {NumChan{px[0]}};
          2: px[k] = '1;
          3: px[k] = '0;
          4: px = px & {NumChan{8'h0F}};
          default: ;
        endcase
        push_pixel(px, steady_mode ? 0 : idle_len());
      end
      in_valid_i <= 1'b0;
      wait_drained();
      steady_mode = 1'b0;
    end

    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rho_pkg.sv
hdl/rho_front.sv
hdl/rho_queue.sv
hdl/rho_back.sv
hdl/rgb_hue_offset_core.sv
bench/hue_shift_checker.sv
bench/tb.sv
